// File: hw/rtl/ascii_to_unsigned_parser_assert.svh
// Assertion macros for the ASCII-to-unsigned parser.
`ifndef ASCII_TO_UNSIGNED_PARSER_ASSERT_SVH
`define ASCII_TO_UNSIGNED_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication: whenever ante holds, cons holds too.
`define ATU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define ATU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define ATU_ASSERT_IMP(label, clk, rst, ante, cons)
`define ATU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/atu_pkg.sv
// Shared constants and the digit decoder of the ASCII-to-unsigned parser.
`default_nettype none
package atu_pkg;

  localparam int ATU_VALUE_WIDTH  = 32;
  localparam int ATU_OFFSET_WIDTH = 16;

  // Characters with special meaning.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  // Radix codes.
  localparam logic [5:0] RADIX_AUTO = 6'd0;
  localparam logic [5:0] RADIX_OCT  = 6'd8;
  localparam logic [5:0] RADIX_DEC  = 6'd10;
  localparam logic [5:0] RADIX_HEX  = 6'd16;

  typedef struct packed {
    logic       alnum;
    logic [5:0] val;
  } digit_t;

  // Decode 0-9, A-Z and a-z into digit values 0 to 35.
  function automatic digit_t decode_digit(input logic [7:0] c);
    digit_t d;
    logic [7:0] off;
    d.alnum = 1'b0;
    d.val   = '0;
    off     = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      off     = c - CH_ZERO;
      d.alnum = 1'b1;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      off     = c - CH_UP_A + 8'd10;
      d.alnum = 1'b1;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      off     = c - CH_LO_A + 8'd10;
      d.alnum = 1'b1;
    end
    d.val = off[5:0];
    return d;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ascii_to_unsigned_parser.sv
// Streaming ASCII-to-unsigned parser, one character per beat.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+-------------------------------
//   in      | in_valid / in_ready | ch, first_char, radix
//   out     | out_valid/out_ready | value, end_offset, converted
//
// One character is taken per cycle while in_ready is high; its whole step is combinational between
// the parse state registers and the result register (one radix multiply-add).
// The terminating character's beat registers its result for out.
// Results sit in an output register backed by one skid register; input stalls
// only while both hold a result. Reset is synchronous and leaves the parser
// idle, waiting for a character flagged as first of a string.
`default_nettype none
`include "ascii_to_unsigned_parser_assert.svh"
module ascii_to_unsigned_parser
  import atu_pkg::*;
#(
  parameter int VALUE_WIDTH  = ATU_VALUE_WIDTH,
  parameter int OFFSET_WIDTH = ATU_OFFSET_WIDTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              ch,
  input  wire logic                    first_char,
  input  wire logic [5:0]              radix,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [VALUE_WIDTH-1:0]       value,
  output logic [OFFSET_WIDTH-1:0]      end_offset,
  output logic                         converted
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SPACE  = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_FIRST  = 3'd4;
  localparam logic [2:0] PH_DIGITS = 3'd5;

  localparam logic [OFFSET_WIDTH-1:0] POS_MAX = '1;

  // Parse state.
  logic [2:0]              phase, phase_next;
  logic                    negative, negative_next;
  logic [5:0]              active_radix, active_radix_next;
  logic [VALUE_WIDTH-1:0]  accumulator, accumulator_next;
  logic [OFFSET_WIDTH-1:0] position, position_next;

  // Skid register behind the output register.
  logic                    skid_valid;
  logic [VALUE_WIDTH-1:0]  skid_value;
  logic [OFFSET_WIDTH-1:0] skid_end_offset;
  logic                    skid_converted;

  // Result of the current beat.
  logic                    res_valid;
  logic [VALUE_WIDTH-1:0]  res_value;
  logic [OFFSET_WIDTH-1:0] res_end_offset;
  logic                    res_converted;

  logic   in_fire;
  logic   produce;
  logic   advance;
  logic   done;
  digit_t dig;
  logic   dig_ok;
  logic   is_space;

  assign in_ready = ~skid_valid;
  assign in_fire  = in_valid & in_ready;
  assign produce  = in_fire & res_valid;

  assign dig      = decode_digit(ch);
  assign is_space = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR);

  // One character step: phases fall through until the character is consumed.
  always_comb begin
    phase_next        = phase;
    negative_next     = negative;
    active_radix_next = active_radix;
    accumulator_next  = accumulator;
    position_next     = position;
    if (first_char) begin
      phase_next        = PH_SPACE;
      negative_next     = 1'b0;
      active_radix_next = radix;
      accumulator_next  = '0;
      position_next     = '0;
    end
    advance        = 1'b0;
    res_valid      = 1'b0;
    res_value      = '0;
    res_end_offset = '0;
    res_converted  = 1'b0;
    done           = (phase_next == PH_IDLE);

    if (!done && phase_next == PH_SPACE) begin
      if (is_space) begin
        advance = 1'b1;
        done    = 1'b1;
      end else begin
        phase_next = PH_PREFIX;
        if (ch == CH_MINUS || ch == CH_PLUS) begin
          negative_next = (ch == CH_MINUS);
          advance       = 1'b1;
          done          = 1'b1;
        end
      end
    end

    if (!done && phase_next == PH_PREFIX) begin
      phase_next = PH_FIRST;
      if (active_radix_next == RADIX_AUTO) begin
        active_radix_next = RADIX_DEC;
        if (ch == CH_ZERO) begin
          active_radix_next = RADIX_OCT;
          phase_next        = PH_ZERO;
          advance           = 1'b1;
          done              = 1'b1;
        end
      end else if (active_radix_next == RADIX_HEX && ch == CH_ZERO) begin
        phase_next = PH_ZERO;
        advance    = 1'b1;
        done       = 1'b1;
      end
    end

    if (!done && phase_next == PH_ZERO) begin
      phase_next = PH_FIRST;
      if (ch == CH_LO_X || ch == CH_UP_X) begin
        active_radix_next = RADIX_HEX;
        advance           = 1'b1;
        done              = 1'b1;
      end
    end

    dig_ok = dig.alnum && (dig.val < active_radix_next);

    // First digit, or a terminator with no digits at all.
    if (!done && phase_next == PH_FIRST) begin
      done = 1'b1;
      if (dig_ok) begin
        accumulator_next = VALUE_WIDTH'(dig.val);
        phase_next       = PH_DIGITS;
        advance          = 1'b1;
      end else begin
        phase_next = PH_IDLE;
        res_valid  = 1'b1;
      end
    end

    // Further digits accumulate; the first non-digit closes the number.
    if (!done && phase_next == PH_DIGITS) begin
      if (dig_ok) begin
        accumulator_next = accumulator_next * VALUE_WIDTH'(active_radix_next)
                         + VALUE_WIDTH'(dig.val);
        advance          = 1'b1;
      end else begin
        phase_next     = PH_IDLE;
        res_valid      = 1'b1;
        res_value      = negative_next ? (VALUE_WIDTH'(0) - accumulator_next)
                                       : accumulator_next;
        res_end_offset = position_next;
        res_converted  = 1'b1;
      end
    end

    if (advance && position_next != POS_MAX) begin
      position_next = position_next + 1'b1;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      negative     <= 1'b0;
      active_radix <= '0;
      accumulator  <= '0;
      position     <= '0;
    end else if (in_fire) begin
      phase        <= phase_next;
      negative     <= negative_next;
      active_radix <= active_radix_next;
      accumulator  <= accumulator_next;
      position     <= position_next;
    end
  end

  // Output register with one skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= produce;
      end
    end else if (!out_valid) begin
      out_valid <= produce;
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  // Result payload follows the same steering as the valid bits.
  always_ff @(posedge clk) begin
    if ((out_valid && out_ready && skid_valid)) begin
      value      <= skid_value;
      end_offset <= skid_end_offset;
      converted  <= skid_converted;
    end else if (!out_valid || out_ready) begin
      value      <= res_value;
      end_offset <= res_end_offset;
      converted  <= res_converted;
    end
    if (out_valid && !out_ready && !skid_valid) begin
      skid_value      <= res_value;
      skid_end_offset <= res_end_offset;
      skid_converted  <= res_converted;
    end
  end

  // The skid entry is only ever filled behind a waiting result.
  `ATU_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  // A result without digits carries a zero value and a zero offset.
  `ATU_ASSERT_IMP(a_empty_result_zero, clk, rst, out_valid && !converted,
                  value == '0 && end_offset == '0)
  // Emitting a result always returns the parser to idle.
  `ATU_ASSERT_NXT(a_result_goes_idle, clk, rst, produce, phase == PH_IDLE)
  // While idle, characters that do not start a string leave it idle.
  `ATU_ASSERT_NXT(a_idle_ignores, clk, rst,
                  in_fire && phase == PH_IDLE && !first_char, phase == PH_IDLE)

endmodule
`default_nettype wire
